// ===== design/shahe_pkg.sv =====
// Shared definitions for the SHA-256 / SHA-224 hash engine.
// Holds the round constants, the initial chaining values and the datapath control type.
// No dependencies.
`default_nettype none

package shahe_pkg;

	localparam int unsigned WORD_W = 32;

	typedef struct packed {
		logic       sched_step;
		logic       sched_mem;
		logic [5:0] kidx;
		logic       round_step;
		logic       v_shift;
		logic       v_load;
	} shahe_ctl_t;

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0:  k = 32'h428A2F98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hB5C0FBCF;
			6'd3:  k = 32'hE9B5DBA5;
			6'd4:  k = 32'h3956C25B;
			6'd5:  k = 32'h59F111F1;
			6'd6:  k = 32'h923F82A4;
			6'd7:  k = 32'hAB1C5ED5;
			6'd8:  k = 32'hD807AA98;
			6'd9:  k = 32'h12835B01;
			6'd10: k = 32'h243185BE;
			6'd11: k = 32'h550C7DC3;
			6'd12: k = 32'h72BE5D74;
			6'd13: k = 32'h80DEB1FE;
			6'd14: k = 32'h9BDC06A7;
			6'd15: k = 32'hC19BF174;
			6'd16: k = 32'hE49B69C1;
			6'd17: k = 32'hEFBE4786;
			6'd18: k = 32'h0FC19DC6;
			6'd19: k = 32'h240CA1CC;
			6'd20: k = 32'h2DE92C6F;
			6'd21: k = 32'h4A7484AA;
			6'd22: k = 32'h5CB0A9DC;
			6'd23: k = 32'h76F988DA;
			6'd24: k = 32'h983E5152;
			6'd25: k = 32'hA831C66D;
			6'd26: k = 32'hB00327C8;
			6'd27: k = 32'hBF597FC7;
			6'd28: k = 32'hC6E00BF3;
			6'd29: k = 32'hD5A79147;
			6'd30: k = 32'h06CA6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27B70A85;
			6'd33: k = 32'h2E1B2138;
			6'd34: k = 32'h4D2C6DFC;
			6'd35: k = 32'h53380D13;
			6'd36: k = 32'h650A7354;
			6'd37: k = 32'h766A0ABB;
			6'd38: k = 32'h81C2C92E;
			6'd39: k = 32'h92722C85;
			6'd40: k = 32'hA2BFE8A1;
			6'd41: k = 32'hA81A664B;
			6'd42: k = 32'hC24B8B70;
			6'd43: k = 32'hC76C51A3;
			6'd44: k = 32'hD192E819;
			6'd45: k = 32'hD6990624;
			6'd46: k = 32'hF40E3585;
			6'd47: k = 32'h106AA070;
			6'd48: k = 32'h19A4C116;
			6'd49: k = 32'h1E376C08;
			6'd50: k = 32'h2748774C;
			6'd51: k = 32'h34B0BCB5;
			6'd52: k = 32'h391C0CB3;
			6'd53: k = 32'h4ED8AA4A;
			6'd54: k = 32'h5B9CCA4F;
			6'd55: k = 32'h682E6FF3;
			6'd56: k = 32'h748F82EE;
			6'd57: k = 32'h78A5636F;
			6'd58: k = 32'h84C87814;
			6'd59: k = 32'h8CC70208;
			6'd60: k = 32'h90BEFFFA;
			6'd61: k = 32'hA4506CEB;
			6'd62: k = 32'hBEF9A3F7;
			default: k = 32'hC67178F2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] iv_word(input logic mode_224, input logic [2:0] idx);
		logic [31:0] w;
		case ({mode_224, idx})
			4'h0: w = 32'h6A09E667;
			4'h1: w = 32'hBB67AE85;
			4'h2: w = 32'h3C6EF372;
			4'h3: w = 32'hA54FF53A;
			4'h4: w = 32'h510E527F;
			4'h5: w = 32'h9B05688C;
			4'h6: w = 32'h1F83D9AB;
			4'h7: w = 32'h5BE0CD19;
			4'h8: w = 32'hC1059ED8;
			4'h9: w = 32'h367CD507;
			4'hA: w = 32'h3070DD17;
			4'hB: w = 32'hF70E5939;
			4'hC: w = 32'hFFC00B31;
			4'hD: w = 32'h68581511;
			4'hE: w = 32'h64F98FA7;
			default: w = 32'hBEFA4FA4;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== design/shahe_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// Used for the message block and the chaining value. No dependencies.
`default_nettype none

module shahe_ram #(
	parameter int unsigned AW = 4,
	parameter int unsigned DW = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/shahe_core.sv =====
// Round datapath: message schedule line, K+W register and the eight working variables.
// Depends on shahe_pkg for the round constants and the control type.
`default_nettype none

module shahe_core (
	input  wire logic                 clk,
	input  wire shahe_pkg::shahe_ctl_t ctl,
	input  wire logic [31:0]          blk_rdata,
	input  wire logic [31:0]          cv_data,
	output logic      [31:0]          wb_data
);

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] wk_q;
	logic [31:0] new_w;
	logic [31:0] t1;
	logic [31:0] t2;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	always_comb begin
		if (ctl.sched_mem) begin
			new_w = blk_rdata;
		end else begin
			new_w = (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10))
				+ w_q[9]
				+ (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3))
				+ w_q[0];
		end
	end

	always_comb begin
		t1 = v_q[7]
			+ (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ wk_q;
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	assign wb_data = cv_data + v_q[0];

	always_ff @(posedge clk) begin
		if (ctl.sched_step) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= new_w;
			wk_q <= new_w + shahe_pkg::round_k(ctl.kidx);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.round_step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else if (ctl.v_shift) begin
			for (int i = 0; i < 7; i++) begin
				v_q[i] <= v_q[i+1];
			end
			v_q[7] <= ctl.v_load ? cv_data : v_q[0];
		end
	end

endmodule

`default_nettype wire

// ===== design/sha256_sha224_hash_engine_unit.sv =====
// SHA-256 / SHA-224 hash engine, top level: control sequencer, block and chaining memories.
// Depends on shahe_pkg, shahe_ram and shahe_core.
//
// Feed the message as big-endian 32-bit words; mark the final word with last_word and give
// its byte count in valid_bytes. Padding and the 64-bit length are added here, with a second
// block when the length does not fit. A word that fills a 16-word block starts a compression
// and no input is taken until it ends. Each block is compressed by a single round unit that
// reads the chaining value from its memory, runs 64 rounds after a schedule lead-in, then
// adds and writes back. The last word adds the padding words and one or two compressions;
// then the digest leaves one word at a time, read from the chaining memory and held until
// taken: eight words for SHA-256, seven for SHA-224.
// Write digest_mode only between messages; the new initial values apply from the next one.
`default_nettype none

module sha256_sha224_hash_engine_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] message_word,
	input  wire logic [2:0]  valid_bytes,
	input  wire logic        last_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [31:0] digest_word,
	output logic      [2:0]  word_index,
	output logic             last_of_digest,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PAD    = 3'd1;
	localparam logic [2:0] S_CVRD   = 3'd2;
	localparam logic [2:0] S_RND    = 3'd3;
	localparam logic [2:0] S_CVWB   = 3'd4;
	localparam logic [2:0] S_OUTRD  = 3'd5;
	localparam logic [2:0] S_OUTCAP = 3'd6;
	localparam logic [2:0] S_OUTWT  = 3'd7;

	localparam logic [1:0] PAD_MARK  = 2'd0;
	localparam logic [1:0] PAD_FILL  = 2'd1;
	localparam logic [1:0] PAD_LENLO = 2'd2;

	localparam logic [2:0] LAST_IDX_256 = 3'd7;
	localparam logic [2:0] LAST_IDX_224 = 3'd6;

	localparam logic [6:0] CNT_LD_END  = 7'd8;
	localparam logic [6:0] CNT_RND_END = 7'd65;

	logic [2:0]  state_q;
	logic [2:0]  ret_q;
	logic [6:0]  cnt_q;
	logic [3:0]  pos_q;
	logic [63:0] len_q;
	logic [1:0]  stage_q;
	logic        mode_q;
	logic        iv_mode_q;
	logic        cv_fresh_q;
	logic        fresh_s1;
	logic [31:0] iv_s1;
	logic [2:0]  idx_q;
	logic        out_valid_q;
	logic [31:0] digest_q;

	logic        in_accept;
	logic        out_accept;
	logic        msg_empty;
	logic        is_last_idx;
	logic [2:0]  nsat;
	logic [31:0] first_word;
	logic [63:0] len_inc;
	logic [31:0] pad_word;
	logic        blk_we;
	logic [31:0] blk_wdata;
	logic [31:0] blk_rdata;
	logic        cv_we;
	logic [2:0]  cv_waddr;
	logic [2:0]  cv_raddr;
	logic [31:0] cv_rdata;
	logic [31:0] cv_data;
	logic [31:0] wb_data;
	shahe_pkg::shahe_ctl_t ctl;

	assign in_ready    = (state_q == S_IDLE);
	assign in_accept   = in_valid & in_ready;
	assign out_accept  = out_valid_q & out_ready;
	assign msg_empty   = (pos_q == 4'd0) && (len_q == 64'd0);
	assign is_last_idx = (idx_q == (mode_q ? LAST_IDX_224 : LAST_IDX_256));

	assign out_valid      = out_valid_q;
	assign digest_word    = digest_q;
	assign word_index     = idx_q;
	assign last_of_digest = is_last_idx;

	always_comb begin
		nsat = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
		case (nsat)
			3'd0:    first_word = 32'h8000_0000;
			3'd1:    first_word = {message_word[31:24], 24'h80_0000};
			3'd2:    first_word = {message_word[31:16], 16'h8000};
			3'd3:    first_word = {message_word[31:8], 8'h80};
			default: first_word = message_word;
		endcase
		if (!last_word) begin
			first_word = message_word;
			len_inc    = 64'd32;
		end else begin
			len_inc = {58'd0, nsat, 3'd0};
		end
	end

	always_comb begin
		case (stage_q)
			PAD_MARK:  pad_word = 32'h8000_0000;
			PAD_FILL:  pad_word = (pos_q == 4'd14) ? len_q[63:32] : 32'd0;
			PAD_LENLO: pad_word = len_q[31:0];
			default:   pad_word = 32'd0;
		endcase
	end

	assign blk_we    = in_accept || (state_q == S_PAD);
	assign blk_wdata = (state_q == S_PAD) ? pad_word : first_word;

	assign cv_raddr = (state_q == S_OUTRD) ? idx_q : cnt_q[2:0];
	assign cv_we    = (state_q == S_CVWB) && (cnt_q != 7'd0);
	assign cv_waddr = cnt_q[2:0] - 3'd1;
	assign cv_data  = fresh_s1 ? iv_s1 : cv_rdata;

	always_comb begin
		ctl.sched_step = (state_q == S_RND) && (cnt_q != 7'd0) && (cnt_q < CNT_RND_END);
		ctl.sched_mem  = (cnt_q <= 7'd16);
		ctl.kidx       = cnt_q[5:0] - 6'd1;
		ctl.round_step = (state_q == S_RND) && (cnt_q >= 7'd2);
		ctl.v_shift    = ((state_q == S_CVRD) || (state_q == S_CVWB)) && (cnt_q != 7'd0);
		ctl.v_load     = (state_q == S_CVRD);
	end

	shahe_ram #(.AW(4), .DW(32)) u_blk_ram (
		.clk   (clk),
		.we    (blk_we),
		.waddr (pos_q),
		.wdata (blk_wdata),
		.raddr (cnt_q[3:0]),
		.rdata (blk_rdata)
	);

	shahe_ram #(.AW(3), .DW(32)) u_cv_ram (
		.clk   (clk),
		.we    (cv_we),
		.waddr (cv_waddr),
		.wdata (wb_data),
		.raddr (cv_raddr),
		.rdata (cv_rdata)
	);

	shahe_core u_core (
		.clk       (clk),
		.ctl       (ctl),
		.blk_rdata (blk_rdata),
		.cv_data   (cv_data),
		.wb_data   (wb_data)
	);

	always_ff @(posedge clk) begin
		iv_s1 <= shahe_pkg::iv_word(iv_mode_q, cv_raddr);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUTCAP) begin
			digest_q <= cv_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			cnt_q       <= 7'd0;
			pos_q       <= 4'd0;
			len_q       <= 64'd0;
			stage_q     <= PAD_MARK;
			mode_q      <= 1'b0;
			iv_mode_q   <= 1'b0;
			cv_fresh_q  <= 1'b1;
			fresh_s1    <= 1'b0;
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			fresh_s1 <= cv_fresh_q;
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			if (out_accept && is_last_idx) begin
				iv_mode_q <= cfg_wr_en ? cfg_wr_data : mode_q;
			end else if (cfg_wr_en && msg_empty) begin
				iv_mode_q <= cfg_wr_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						pos_q   <= pos_q + 4'd1;
						len_q   <= len_q + len_inc;
						stage_q <= (nsat == 3'd4) ? PAD_MARK : PAD_FILL;
						ret_q   <= last_word ? S_PAD : S_IDLE;
						cnt_q   <= 7'd0;
						if (pos_q == 4'd15) begin
							state_q <= S_CVRD;
						end else if (last_word) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					pos_q <= pos_q + 4'd1;
					cnt_q <= 7'd0;
					case (stage_q)
						PAD_MARK: stage_q <= PAD_FILL;
						PAD_FILL: begin
							if (pos_q == 4'd14) begin
								stage_q <= PAD_LENLO;
							end
						end
						default: stage_q <= PAD_LENLO;
					endcase
					if (pos_q == 4'd15) begin
						state_q <= S_CVRD;
						ret_q   <= (stage_q == PAD_LENLO) ? S_OUTRD : S_PAD;
					end
				end
				S_CVRD: begin
					if (cnt_q == CNT_LD_END) begin
						cnt_q   <= 7'd0;
						state_q <= S_RND;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_RND: begin
					if (cnt_q == CNT_RND_END) begin
						cnt_q   <= 7'd0;
						state_q <= S_CVWB;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_CVWB: begin
					if (cnt_q == CNT_LD_END) begin
						cnt_q      <= 7'd0;
						cv_fresh_q <= 1'b0;
						idx_q      <= 3'd0;
						state_q    <= ret_q;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_OUTRD: begin
					state_q <= S_OUTCAP;
				end
				S_OUTCAP: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OUTWT;
				end
				S_OUTWT: begin
					if (out_accept) begin
						out_valid_q <= 1'b0;
						if (is_last_idx) begin
							idx_q      <= 3'd0;
							pos_q      <= 4'd0;
							len_q      <= 64'd0;
							cv_fresh_q <= 1'b1;
							state_q    <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 3'd1;
							state_q <= S_OUTRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_only_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == S_OUTWT))
		else $error("digest word presented outside the output wait state");

	a_no_block_write_in_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RND) |-> !blk_we)
		else $error("block memory written during compression");

	a_digest_after_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUTRD) |-> (pos_q == 4'd0) && !cv_fresh_q)
		else $error("digest read without a completed final block");

	a_fresh_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		(out_accept && is_last_idx) |=> cv_fresh_q && (state_q == S_IDLE))
		else $error("chaining value not returned to initial values after digest");

endmodule

`default_nettype wire

// ===== tb/sha256_sha224_hash_engine_unit_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the SHA-256 / SHA-224 hash engine. It watches the input, output and mode-write
// transfers, hashes the accepted words with its own copy of the engine state and checks each
// digest word. It needs only the port signals of the engine.
module sha256_sha224_hash_engine_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] message_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last_word,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_of_digest,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	output int          error_count,
	output int          pending_words,
	output int          digest_words_seen
);

	localparam logic [2047:0] ROUND_K = {
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	localparam logic [255:0] IV_SHA256 = {
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [255:0] IV_SHA224 = {
		32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
		32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
	};

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        final_word;
	} digest_beat_t;

	digest_beat_t digest_due_q[$];
	digest_beat_t beat;
	logic [31:0]  chain_h [8];
	logic [31:0]  block_buf [16];
	logic [3:0]   fill_pos;
	logic [63:0]  bit_count;
	logic         sha224_sel;
	int           mismatches = 0;
	int           seen = 0;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic load_initial_hash();
		int i;
		for (i = 0; i < 8; i++)
			chain_h[i] = sha224_sel ? IV_SHA224[(7 - i) * 32 +: 32] : IV_SHA256[(7 - i) * 32 +: 32];
	endtask

	task automatic compress_block();
		logic [31:0] sched [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, ch, maj, t1, t2;
		int t;
		for (t = 0; t < 16; t++)
			sched[t] = block_buf[t];
		for (t = 16; t < 64; t++) begin
			s0 = ror32(sched[t - 15], 7) ^ ror32(sched[t - 15], 18) ^ (sched[t - 15] >> 3);
			s1 = ror32(sched[t - 2], 17) ^ ror32(sched[t - 2], 19) ^ (sched[t - 2] >> 10);
			sched[t] = s1 + sched[t - 7] + s0 + sched[t - 16];
		end
		for (t = 0; t < 8; t++)
			v[t] = chain_h[t];
		for (t = 0; t < 64; t++) begin
			s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
			maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t1 = v[7] + s1 + ch + ROUND_K[(63 - t) * 32 +: 32] + sched[t];
			t2 = s0 + maj;
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (t = 0; t < 8; t++)
			chain_h[t] = chain_h[t] + v[t];
	endtask

	task automatic push_block_word(input logic [31:0] w);
		block_buf[fill_pos] = w;
		fill_pos = fill_pos + 4'd1;
		if (fill_pos == 4'd0)
			compress_block();
	endtask

	task automatic absorb_word(input logic [31:0] w, input logic [2:0] nb, input logic lst);
		logic [31:0] keep;
		int used, count, k;
		if (!lst) begin
			bit_count = bit_count + 64'd32;
			push_block_word(w);
		end else begin
			used = (nb > 3'd4) ? 4 : int'(nb);
			bit_count = bit_count + 64'(used * 8);
			if (used == 4) begin
				push_block_word(w);
				push_block_word(32'h8000_0000);
			end else begin
				keep = (used == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - 8 * used));
				push_block_word((w & keep) | (32'h80 << (24 - 8 * used)));
			end
			// no room for the length: close this block with zeros
			if (fill_pos == 4'd15)
				push_block_word(32'd0);
			while (fill_pos < 4'd14)
				push_block_word(32'd0);
			push_block_word(bit_count[63:32]);
			push_block_word(bit_count[31:0]);
			count = sha224_sel ? 7 : 8;
			for (k = 0; k < count; k++) begin
				beat.word = chain_h[k];
				beat.index = 3'(k);
				beat.final_word = (k == count - 1);
				digest_due_q.push_back(beat);
			end
			fill_pos = 4'd0;
			bit_count = 64'd0;
			load_initial_hash();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sha224_sel = 1'b0;
			fill_pos = 4'd0;
			bit_count = 64'd0;
			for (int i = 0; i < 16; i++)
				block_buf[i] = 32'd0;
			load_initial_hash();
			digest_due_q.delete();
		end else begin
			if (cfg_wr_en) begin
				sha224_sel = cfg_wr_data;
				if (fill_pos == 4'd0 && bit_count == 64'd0)
					load_initial_hash();
			end
			if (out_valid && out_ready) begin
				seen++;
				if (digest_due_q.size() == 0) begin
					mismatches++;
					$display("%0t: digest word %h index %0d last %0b arrived with none expected",
						$time, digest_word, word_index, last_of_digest);
				end else begin
					beat = digest_due_q.pop_front();
					if (digest_word !== beat.word || word_index !== beat.index ||
							last_of_digest !== beat.final_word) begin
						mismatches++;
						$display("%0t: digest mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
							$time, beat.word, beat.index, beat.final_word,
							digest_word, word_index, last_of_digest);
					end
				end
			end
			if (in_valid && in_ready)
				absorb_word(message_word, valid_bytes, last_word);
		end
		error_count <= mismatches;
		pending_words <= digest_due_q.size();
		digest_words_seen <= seen;
	end

endmodule

// ===== tb/sha256_sha224_hash_engine_unit_tb.sv =====
`timescale 1ns / 1ps
// Top of the hash engine testbench: clock, reset, message stimulus, output back-pressure and
// the verdict. Depends on sha256_sha224_hash_engine_unit and sha256_sha224_hash_engine_unit_checker.
module sha256_sha224_hash_engine_unit_tb;

	typedef enum logic {
		MODE_SHA256 = 1'b0,
		MODE_SHA224 = 1'b1
	} digest_mode_e;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 30;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] message_word;
	logic [2:0]  valid_bytes;
	logic        last_word;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_of_digest;
	logic        cfg_wr_en;
	logic        cfg_wr_data;

	int          error_count;
	int          pending_words;
	int          digest_words_seen;

	int          send_idle = 0;
	int          recv_idle = 0;
	logic        hold_req = 1'b0;
	int          hold_left = 0;
	bit          hold_taken = 1'b0;
	int          words_sent = 0;
	int          messages_sent = 0;
	int          mode_writes = 0;
	int unsigned cycle_count = 0;

	sha256_sha224_hash_engine_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.message_word   (message_word),
		.valid_bytes    (valid_bytes),
		.last_word      (last_word),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_of_digest (last_of_digest),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data)
	);

	sha256_sha224_hash_engine_unit_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.message_word      (message_word),
		.valid_bytes       (valid_bytes),
		.last_word         (last_word),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.digest_word       (digest_word),
		.word_index        (word_index),
		.last_of_digest    (last_of_digest),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.error_count       (error_count),
		.pending_words     (pending_words),
		.digest_words_seen (digest_words_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("sha256_sha224_hash_engine_unit_tb: done, errors");
			$finish;
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic put_word(input logic [31:0] w, input logic [2:0] nb, input logic lst);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		message_word <= w;
		valid_bytes <= nb;
		last_word <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
		if (lst)
			messages_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_words != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input digest_mode_e m);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mode_writes++;
	endtask

	task automatic send_message(input int nfull, input bit noisy);
		int i;
		for (i = 0; i < nfull; i++)
			put_word($urandom, noisy ? 3'($urandom_range(7)) : 3'd4, 1'b0);
		put_word($urandom, 3'($urandom_range(7)), 1'b1);
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input int word_budget);
		int start, sel, len;
		send_idle = send_pct;
		recv_idle = recv_pct;
		start = words_sent;
		while (words_sent - start < word_budget) begin
			if ($urandom_range(2) == 0)
				set_mode(digest_mode_e'($urandom_range(1)));
			sel = $urandom_range(9);
			if (sel < 4)
				len = $urandom_range(5);
			else if (sel < 7)
				len = $urandom_range(16, 12);
			else if (sel < 9)
				len = $urandom_range(31, 6);
			else
				len = $urandom_range(47, 28);
			send_message(len, $urandom_range(4) == 0);
		end
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		message_word = 32'd0;
		valid_bytes = 3'd0;
		last_word = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = MODE_SHA256;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_mode(MODE_SHA256);
		put_word(32'hDEAD_BEEF, 3'd0, 1'b1);
		put_word(32'h6162_63FF, 3'd3, 1'b1);
		set_mode(MODE_SHA224);
		put_word(32'hFFFF_FFFF, 3'd7, 1'b1);
		put_word(32'h0000_0000, 3'd6, 1'b0);
		put_word(32'h1234_5678, 3'd5, 1'b1);
		set_mode(MODE_SHA256);
		put_word(32'hFFFF_FFFF, 3'd4, 1'b0);
		put_word(32'h0000_0000, 3'd0, 1'b0);
		put_word(32'hA5A5_5A5A, 3'd2, 1'b0);
		for (i = 0; i < 11; i++)
			put_word($urandom, 3'd4, 1'b0);
		put_word(32'h80FF_FFFF, 3'd1, 1'b1);
		put_word(32'h0000_0000, 3'd4, 1'b1);
		drain();

		run_phase(14, 64, 60);
		run_phase(64, 14, 60);

		// fill the engine while the output is held off
		set_mode(MODE_SHA224);
		send_idle = 0;
		recv_idle = 0;
		hold_req <= 1'b1;
		for (i = 0; i < 4; i++)
			send_message($urandom_range(6, 2), 1'b0);
		drain();

		run_phase(0, 0, 60);
		drain();

		$display("Run covered %0d messages, %0d words, %0d mode writes and %0d digest words,",
			messages_sent, words_sent, mode_writes, digest_words_seen);
		$display("with both digest modes, padding spill blocks and a %0d-cycle output hold-off.",
			HOLD_CYCLES);
		if (error_count == 0 && pending_words == 0)
			$display("sha256_sha224_hash_engine_unit_tb: done, clean");
		else
			$display("sha256_sha224_hash_engine_unit_tb: done, errors");
		$finish;
	end

endmodule
